FILE: hw/rtl/rc4sc_pkg.sv
`default_nettype none

package rc4sc_pkg;

    localparam int BYTE_W        = 8;
    localparam int TABLE_DEPTH   = 256;
    localparam int ADDR_W        = 8;
    localparam int CFG_W         = 64;
    localparam int KEY_BYTES_DEF = 8;
    localparam int KEY_IDX_W     = 3;

    // request kinds carried on tuser
    localparam logic OP_INIT = 1'b0;
    localparam logic OP_DATA = 1'b1;

endpackage : rc4sc_pkg

`default_nettype wire

FILE: hw/rtl/rc4sc_ram.sv
`default_nettype none

module rc4sc_ram #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = 256,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  wire logic              aclk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [DATA_W-1:0] wdata,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic      [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [DEPTH];

    // read returns the old contents on a same-address write
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule : rc4sc_ram

`default_nettype wire

FILE: hw/rtl/rc4_stream_cipher.sv
`default_nettype none
// data request: S[j] read, S[i] and S[j] written, S[t] read on the single-write, single-read
//   permutation ram, result registered once the output is free; then the next one is taken
// init request: identity fill of all 256 entries, then a keyed swap per entry; the block
//   takes no request until it is done, and it gives no result
// reset (aresetn low, synchronous): indices and key cleared, output empty; the permutation
//   holds nothing meaningful until the first init request
module rc4_stream_cipher
    import rc4sc_pkg::*;
#(
    parameter int KEY_BYTES = KEY_BYTES_DEF
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    // configuration: key bytes little-endian, byte 0 in bits 7:0
    input  wire logic             cfg_wr_en,
    input  wire logic [CFG_W-1:0] cfg_wr_data,
    // request channel
    input  wire logic             s_tvalid,
    output logic                  s_tready,
    input  wire logic [7:0]       s_tdata,   // [7:0] data_in
    input  wire logic [0:0]       s_tuser,   // [0] op
    // result channel
    output logic                  m_tvalid,
    input  wire logic             m_tready,
    output logic      [7:0]       m_tdata    // [7:0] data_out
);

    localparam int KEY_W = KEY_BYTES * BYTE_W;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_FILL,     // identity fill, one entry a cycle
        ST_KS_RD_I,  // key schedule: read S[n]
        ST_KS_RD_J,  // key schedule: update j, read S[j]
        ST_KS_WR_I,  // key schedule: S[n] <= S[j]
        ST_KS_WR_J,  // key schedule: S[j] <= old S[n]
        ST_D_RD_J,   // data: S[i] arrives, update j, read S[j]
        ST_D_WR_I,   // data: S[i] <= S[j]
        ST_D_WR_J,   // data: S[j] <= old S[i], read S[t]
        ST_D_OUT     // data: keystream byte arrives, load output
    } state_t;

    state_t                 state_reg, state_next;
    logic [KEY_W-1:0]       key_reg, key_next;
    logic [ADDR_W-1:0]      i_reg, i_next;
    logic [ADDR_W-1:0]      j_reg, j_next;
    logic [ADDR_W-1:0]      n_reg, n_next;
    logic [KEY_IDX_W-1:0]   kidx_reg, kidx_next;
    logic [BYTE_W-1:0]      sa_reg, sa_next;     // S[i] (or S[n] in the key schedule)
    logic [BYTE_W-1:0]      sb_reg, sb_next;     // S[j]
    logic [ADDR_W-1:0]      t_reg, t_next;
    logic                   fwd_reg, fwd_next;   // t hit j during the final write
    logic [BYTE_W-1:0]      din_reg, din_next;
    logic                   m_tvalid_reg, m_tvalid_next;
    logic [BYTE_W-1:0]      m_tdata_reg, m_tdata_next;

    // permutation ram port signals
    logic                   ram_we;
    logic [ADDR_W-1:0]      ram_waddr;
    logic [BYTE_W-1:0]      ram_wdata;
    logic [ADDR_W-1:0]      ram_raddr;
    logic [BYTE_W-1:0]      ram_rdata;

    logic [BYTE_W-1:0]      key_byte;
    logic [ADDR_W-1:0]      j_sum;
    logic [ADDR_W-1:0]      t_sum;
    logic [BYTE_W-1:0]      ks_byte;
    logic                   s_accept;
    logic                   out_free;

    rc4sc_ram #(
        .DATA_W (BYTE_W),
        .DEPTH  (TABLE_DEPTH),
        .ADDR_W (ADDR_W)
    ) u_perm_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign s_tready = (state_reg == ST_IDLE);
    assign s_accept = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // key byte for the current keyed swap, cycling over KEY_BYTES
    assign key_byte = key_reg[kidx_reg*BYTE_W +: BYTE_W];

    // ram read data is S[n] in the key schedule and S[i] for a data request
    assign j_sum = (state_reg == ST_KS_RD_J) ? ADDR_W'(j_reg + ram_rdata + key_byte)
                                             : ADDR_W'(j_reg + ram_rdata);
    assign t_sum = ADDR_W'(sa_reg + sb_reg);

    // the read of S[t] shares its edge with the write of S[j], so that case is forwarded
    assign ks_byte = fwd_reg ? sa_reg : ram_rdata;

    always_comb begin
        state_next    = state_reg;
        key_next      = key_reg;
        i_next        = i_reg;
        j_next        = j_reg;
        n_next        = n_reg;
        kidx_next     = kidx_reg;
        sa_next       = sa_reg;
        sb_next       = sb_reg;
        t_next        = t_reg;
        fwd_next      = fwd_reg;
        din_next      = din_reg;
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;

        ram_we    = 1'b0;
        ram_waddr = n_reg;
        ram_wdata = n_reg;
        ram_raddr = t_reg;

        if (m_tready) begin
            m_tvalid_next = 1'b0;
        end

        if (cfg_wr_en) begin
            key_next = cfg_wr_data[KEY_W-1:0];
        end

        unique case (state_reg)
            ST_IDLE: begin
                // keep S[i+1] coming so a data request finds it in ST_D_RD_J
                ram_raddr = ADDR_W'(i_reg + 1'b1);
                if (s_accept) begin
                    if (s_tuser[0] == OP_INIT) begin
                        n_next     = '0;
                        state_next = ST_FILL;
                    end else begin
                        i_next     = ADDR_W'(i_reg + 1'b1);
                        din_next   = s_tdata;
                        state_next = ST_D_RD_J;
                    end
                end
            end

            ST_FILL: begin
                ram_we    = 1'b1;
                ram_waddr = n_reg;
                ram_wdata = n_reg;
                n_next    = ADDR_W'(n_reg + 1'b1);
                if (n_reg == ADDR_W'(TABLE_DEPTH - 1)) begin
                    j_next     = '0;
                    kidx_next  = '0;
                    state_next = ST_KS_RD_I;
                end
            end

            ST_KS_RD_I: begin
                ram_raddr  = n_reg;
                state_next = ST_KS_RD_J;
            end

            ST_KS_RD_J: begin
                ram_raddr  = j_sum;
                j_next     = j_sum;
                sa_next    = ram_rdata;
                state_next = ST_KS_WR_I;
            end

            ST_KS_WR_I: begin
                ram_we     = 1'b1;
                ram_waddr  = n_reg;
                ram_wdata  = ram_rdata;
                state_next = ST_KS_WR_J;
            end

            ST_KS_WR_J: begin
                ram_we    = 1'b1;
                ram_waddr = j_reg;
                ram_wdata = sa_reg;
                n_next    = ADDR_W'(n_reg + 1'b1);
                if (kidx_reg == KEY_IDX_W'(KEY_BYTES - 1)) begin
                    kidx_next = '0;
                end else begin
                    kidx_next = KEY_IDX_W'(kidx_reg + 1'b1);
                end
                if (n_reg == ADDR_W'(TABLE_DEPTH - 1)) begin
                    i_next     = '0;
                    j_next     = '0;
                    state_next = ST_IDLE;
                end else begin
                    state_next = ST_KS_RD_I;
                end
            end

            ST_D_RD_J: begin
                ram_raddr  = j_sum;
                j_next     = j_sum;
                sa_next    = ram_rdata;
                state_next = ST_D_WR_I;
            end

            ST_D_WR_I: begin
                ram_we     = 1'b1;
                ram_waddr  = i_reg;
                ram_wdata  = ram_rdata;
                sb_next    = ram_rdata;
                state_next = ST_D_WR_J;
            end

            ST_D_WR_J: begin
                ram_we     = 1'b1;
                ram_waddr  = j_reg;
                ram_wdata  = sa_reg;
                ram_raddr  = t_sum;
                t_next     = t_sum;
                fwd_next   = (t_sum == j_reg);
                state_next = ST_D_OUT;
            end

            ST_D_OUT: begin
                // re-reading S[t] keeps the read data steady while the output is full
                ram_raddr = t_reg;
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = din_reg ^ ks_byte;
                    state_next    = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            key_reg      <= '0;
            i_reg        <= '0;
            j_reg        <= '0;
            n_reg        <= '0;
            kidx_reg     <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            key_reg      <= key_next;
            i_reg        <= i_next;
            j_reg        <= j_next;
            n_reg        <= n_next;
            kidx_reg     <= kidx_next;
            m_tvalid_reg <= m_tvalid_next;
        end
        sa_reg      <= sa_next;
        sb_reg      <= sb_next;
        t_reg       <= t_next;
        fwd_reg     <= fwd_next;
        din_reg     <= din_next;
        m_tdata_reg <= m_tdata_next;
    end

endmodule : rc4_stream_cipher

`default_nettype wire
